@@ design/rtdm_pkg.sv @@
// Shared types, opcodes and the sequencer microprogram of the task delay and ready manager.
package rtdm_pkg;

    localparam int NUM_TASKS_DEF   = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_DELAY   = 3'd1,
        OP_PEND    = 3'd2,
        OP_SEND    = 3'd3,
        OP_SUSPEND = 3'd4,
        OP_RESUME  = 3'd5
    } t_opcode;

    typedef enum logic [3:0] {
        A_IDLE,
        A_IDX_CLR,
        A_TICK,
        A_EMIT,
        A_DELAY,
        A_PEND,
        A_SEND,
        A_SUSPEND,
        A_RESUME
    } t_action;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_LOOP,
        C_WAIT,
        C_DISPATCH
    } t_cond;

    typedef logic [3:0] t_step;

    localparam t_step S_IDLE      = 4'd0;
    localparam t_step S_TICK_INIT = 4'd1;
    localparam t_step S_TICK_WALK = 4'd2;
    localparam t_step S_EMIT      = 4'd3;
    localparam t_step S_DELAY     = 4'd4;
    localparam t_step S_PEND      = 4'd5;
    localparam t_step S_SEND      = 4'd6;
    localparam t_step S_SUSPEND   = 4'd7;
    localparam t_step S_RESUME    = 4'd8;

    typedef struct packed {
        t_action action;
        t_cond   cond;
        t_step   target;
    } t_uword;

    typedef struct packed {
        logic  fire;
        t_step entry;
        logic  last;
        logic  out_busy;
    } t_seq_stat;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        unique case (step)
            S_IDLE:      w = '{A_IDLE,    C_DISPATCH, S_IDLE};
            S_TICK_INIT: w = '{A_IDX_CLR, C_NEXT,     S_TICK_WALK};
            S_TICK_WALK: w = '{A_TICK,    C_LOOP,     S_EMIT};
            S_EMIT:      w = '{A_EMIT,    C_WAIT,     S_IDLE};
            S_DELAY:     w = '{A_DELAY,   C_JUMP,     S_EMIT};
            S_PEND:      w = '{A_PEND,    C_JUMP,     S_EMIT};
            S_SEND:      w = '{A_SEND,    C_JUMP,     S_EMIT};
            S_SUSPEND:   w = '{A_SUSPEND, C_JUMP,     S_EMIT};
            S_RESUME:    w = '{A_RESUME,  C_JUMP,     S_EMIT};
            default:     w = '{A_IDLE,    C_JUMP,     S_IDLE};
        endcase
        return w;
    endfunction

    function automatic t_step entry_of(input logic [2:0] op);
        t_step s;
        unique case (op)
            OP_TICK:    s = S_TICK_INIT;
            OP_DELAY:   s = S_DELAY;
            OP_PEND:    s = S_PEND;
            OP_SEND:    s = S_SEND;
            OP_SUSPEND: s = S_SUSPEND;
            OP_RESUME:  s = S_RESUME;
            default:    s = S_EMIT;
        endcase
        return s;
    endfunction

endpackage

@@ design/rtdm_if.sv @@
// Command and result channel interfaces of the task delay and ready manager.
interface rtdm_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [3:0]  caller_task;
    logic [3:0]  target_task;
    logic [15:0] delay_ticks;

    modport source (output valid, output opcode, output caller_task, output target_task,
                    output delay_ticks, input ready);
    modport sink   (input valid, input opcode, input caller_task, input target_task,
                    input delay_ticks, output ready);
endinterface

interface rtdm_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] ready_mask;
    logic [15:0] woken_mask;
    logic [3:0]  next_task;
    logic        any_ready;

    modport source (output valid, output ready_mask, output woken_mask, output next_task,
                    output any_ready, input ready);
    modport sink   (input valid, input ready_mask, input woken_mask, input next_task,
                    input any_ready, output ready);
endinterface

@@ design/rtdm_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module rtdm_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rtdm_pkg::t_seq_stat i_stat,
    output rtdm_pkg::t_uword   o_uword
);
    import rtdm_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        w = ucode(r_step);
        unique case (w.cond)
            C_NEXT:     n_step = r_step + 4'd1;
            C_JUMP:     n_step = w.target;
            C_LOOP:     n_step = i_stat.last ? w.target : r_step;
            C_WAIT:     n_step = i_stat.out_busy ? r_step : w.target;
            C_DISPATCH: n_step = i_stat.fire ? i_stat.entry : r_step;
            default:    n_step = S_IDLE;
        endcase
    end

    assign o_uword = w;

endmodule

@@ design/rtos_task_delay_and_ready_manager.sv @@
// Top level of the task delay and ready manager: task bitmaps, tick counter memory, result register.
//
// Usage:
//   i_cmd carries one command beat: opcode, caller_task, target_task, delay_ticks.
//   o_res carries one result beat per command: ready_mask, woken_mask,
//   next_task and any_ready, all taken after the command has been applied.
//   Commands are handled one at a time; i_cmd.ready is high while the
//   sequencer waits for a command.
//   A tick walks the tick counter memory one task per cycle through its
//   single registered read port before the result is emitted. Delay,
//   pend, send, suspend and resume apply their action and then emit the
//   result; an unused opcode emits the result directly. A new command is
//   accepted only once the sequencer is back in its idle step.
//   The result sits in an output register, so the next command is accepted
//   while a result waits; if the receiver still holds the previous result
//   when the next one is ready, the sequencer holds until it is taken.
//   Reset clears all ready and wait bits and the output valid. Tick counters
//   are not cleared; each is loaded by the delay that arms it.
module rtos_task_delay_and_ready_manager #(
    parameter int NUM_TASKS   = rtdm_pkg::NUM_TASKS_DEF,
    parameter int COUNT_WIDTH = rtdm_pkg::COUNT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rtdm_cmd_if.sink  i_cmd,
    rtdm_res_if.source o_res
);
    import rtdm_pkg::*;

    localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam logic [63:0] CntMax = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam logic [TW-1:0] LastIdx = TW'(NUM_TASKS - 1);

    t_uword    uw;
    t_seq_stat stat;

    logic [3:0]  r_caller;
    logic [3:0]  r_target;
    logic [15:0] r_ticks;

    logic [NUM_TASKS-1:0] r_ready;
    logic [NUM_TASKS-1:0] r_dwait;
    logic [NUM_TASKS-1:0] r_swait;
    logic [NUM_TASKS-1:0] r_before;
    logic [NUM_TASKS-1:0] n_ready;
    logic [NUM_TASKS-1:0] n_dwait;
    logic [NUM_TASKS-1:0] n_swait;

    logic [TW-1:0]          r_idx;
    logic [TW-1:0]          rd_addr;
    logic [COUNT_WIDTH-1:0] mem [NUM_TASKS];
    logic [COUNT_WIDTH-1:0] r_rdata;
    logic                   we;
    logic [TW-1:0]          wa;
    logic [COUNT_WIDTH-1:0] wd;

    logic                   accept;
    logic                   caller_ok;
    logic                   target_ok;
    logic [TW-1:0]          caller_idx;
    logic [TW-1:0]          target_idx;
    logic [COUNT_WIDTH-1:0] load_val;
    logic [TW-1:0]          pe;
    logic [63:0]            ready_ext;
    logic [63:0]            woken_ext;
    logic                   emit;

    logic        r_out_valid;
    logic [15:0] r_out_ready;
    logic [15:0] r_out_woken;
    logic [3:0]  r_out_next;
    logic        r_out_any;

    rtdm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uword (uw)
    );

    assign i_cmd.ready = (uw.action == A_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;

    assign stat.fire     = accept;
    assign stat.entry    = entry_of(i_cmd.opcode);
    assign stat.last     = (r_idx == LastIdx);
    assign stat.out_busy = r_out_valid && !o_res.ready;

    assign caller_ok  = 32'(r_caller) < 32'(NUM_TASKS);
    assign target_ok  = 32'(r_target) < 32'(NUM_TASKS);
    assign caller_idx = TW'(r_caller);
    assign target_idx = TW'(r_target);
    assign load_val   = (64'(r_ticks) > CntMax) ? CntMax[COUNT_WIDTH-1:0]
                                                : COUNT_WIDTH'(r_ticks);

    // hold the command beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_caller <= i_cmd.caller_task;
            r_target <= i_cmd.target_task;
            r_ticks  <= i_cmd.delay_ticks;
        end
    end

    always_comb begin
        n_ready = r_ready;
        n_dwait = r_dwait;
        n_swait = r_swait;
        we      = 1'b0;
        wa      = r_idx;
        wd      = r_rdata - COUNT_WIDTH'(1);
        rd_addr = r_idx + TW'(1);
        case (uw.action)
            A_IDX_CLR: begin
                rd_addr = '0;
            end
            A_TICK: begin
                if (r_dwait[r_idx]) begin
                    if (r_rdata == '0) begin
                        n_ready[r_idx] = 1'b1;
                        n_dwait[r_idx] = 1'b0;
                    end else begin
                        we = 1'b1;
                    end
                end
            end
            A_DELAY: begin
                if (r_ticks != '0 && caller_ok) begin
                    n_ready[caller_idx] = 1'b0;
                    n_dwait[caller_idx] = 1'b1;
                    we = 1'b1;
                    wa = caller_idx;
                    wd = load_val;
                end
            end
            A_PEND: begin
                if (caller_ok) begin
                    n_swait[caller_idx] = 1'b1;
                    n_ready[caller_idx] = 1'b0;
                end
            end
            A_SEND: begin
                if (target_ok && r_target != r_caller && r_swait[target_idx]) begin
                    n_swait[target_idx] = 1'b0;
                    n_ready[target_idx] = 1'b1;
                end
            end
            A_SUSPEND: begin
                if (target_ok) begin
                    n_ready[target_idx] = 1'b0;
                end
            end
            A_RESUME: begin
                if (target_ok) begin
                    n_ready[target_idx] = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= '0;
            r_dwait <= '0;
            r_swait <= '0;
        end else begin
            r_ready <= n_ready;
            r_dwait <= n_dwait;
            r_swait <= n_swait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_before <= r_ready;
        end
        if (uw.action == A_IDX_CLR) begin
            r_idx <= '0;
        end else if (uw.action == A_TICK) begin
            r_idx <= r_idx + TW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rdata <= mem[rd_addr];
    end

    always_comb begin
        pe = '0;
        for (int i = NUM_TASKS - 1; i >= 0; i--) begin
            if (r_ready[i]) begin
                pe = TW'(i);
            end
        end
    end

    assign ready_ext = 64'(r_ready);
    assign woken_ext = 64'(r_ready & ~r_before);
    assign emit      = (uw.action == A_EMIT) && !stat.out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_ready <= ready_ext[15:0];
            r_out_woken <= woken_ext[15:0];
            r_out_next  <= 4'(pe);
            r_out_any   <= |r_ready;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.ready_mask = r_out_ready;
    assign o_res.woken_mask = r_out_woken;
    assign o_res.next_task  = r_out_next;
    assign o_res.any_ready  = r_out_any;

endmodule
